// File: rtl/ubxfp_pkg.sv
// ----------------------------------------------------------------------------
// ubxfp_pkg
// Shared types and constants for the UBX frame parser: register map,
// queue entry format between front and back, result kinds.
// ----------------------------------------------------------------------------
package ubxfp_pkg;

  // Configuration register map (byte address = 4 * index)
  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] REG_MAX_LEN     = 2'd2;

  localparam logic [7:0]  SYNC_FIRST_RST  = 8'hB5;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'h62;
  localparam logic [15:0] MAX_LEN_RST     = 16'd255;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_BAD     = 2'd2;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Byte roles assigned by the front end
  typedef enum logic [2:0] {
    OP_CLASS = 3'd0,
    OP_ID    = 3'd1,
    OP_LENLO = 3'd2,
    OP_LENHI = 3'd3,
    OP_PAY   = 3'd4,
    OP_CKA   = 3'd5,
    OP_CKB   = 3'd6
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } qent_t;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] max_len;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] frame_len;
  } res_t;

endpackage

// File: rtl/ubxfp_front.sv
// ----------------------------------------------------------------------------
// ubxfp_front
// Sync hunt and framing: tags each byte of a frame with its role and pushes
// it to the queue. Hunt bytes produce no entry; a rejected frame's header bytes are still pushed.
// ----------------------------------------------------------------------------
module ubxfp_front (
  input  logic                clk,
  input  logic                rst,
  input  ubxfp_pkg::cfg_t     cfg,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  output logic                push,
  output ubxfp_pkg::qent_t    push_ent
);
  import ubxfp_pkg::*;

  typedef enum logic [8:0] {
    PH_HUNT1   = 9'b000000001,
    PH_HUNT2   = 9'b000000010,
    PH_CLASS   = 9'b000000100,
    PH_ID      = 9'b000001000,
    PH_LENLO   = 9'b000010000,
    PH_LENHI   = 9'b000100000,
    PH_PAYLOAD = 9'b001000000,
    PH_CKA     = 9'b010000000,
    PH_CKB     = 9'b100000000
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  len_lo, len_lo_next;
  logic [15:0] cur_len, cur_len_next;
  logic [15:0] pay_count, pay_count_next;
  logic [15:0] hdr_len;
  logic [15:0] count_inc;

  assign hdr_len   = {rx_byte, len_lo};
  assign count_inc = pay_count + 16'd1;

  always_comb begin
    phase_next     = phase;
    len_lo_next    = len_lo;
    cur_len_next   = cur_len;
    pay_count_next = pay_count;
    push           = 1'b0;
    push_ent.data  = rx_byte;
    push_ent.op    = OP_CLASS;
    if (accept) begin
      unique case (phase)
        PH_HUNT2: begin
          phase_next = (rx_byte == cfg.sync_second) ? PH_CLASS : PH_HUNT1;
        end
        PH_CLASS: begin
          push       = 1'b1;
          push_ent.op = OP_CLASS;
          phase_next = PH_ID;
        end
        PH_ID: begin
          push       = 1'b1;
          push_ent.op = OP_ID;
          phase_next = PH_LENLO;
        end
        PH_LENLO: begin
          push        = 1'b1;
          push_ent.op = OP_LENLO;
          len_lo_next = rx_byte;
          phase_next  = PH_LENHI;
        end
        PH_LENHI: begin
          push           = 1'b1;
          push_ent.op    = OP_LENHI;
          cur_len_next   = hdr_len;
          pay_count_next = '0;
          phase_next     = (hdr_len != '0 && hdr_len <= cfg.max_len) ? PH_PAYLOAD
                                                                      : PH_HUNT1;
        end
        PH_PAYLOAD: begin
          push           = 1'b1;
          push_ent.op    = OP_PAY;
          pay_count_next = count_inc;
          if (count_inc >= cur_len) begin
            phase_next = PH_CKA;
          end
        end
        PH_CKA: begin
          push        = 1'b1;
          push_ent.op = OP_CKA;
          phase_next  = PH_CKB;
        end
        PH_CKB: begin
          push        = 1'b1;
          push_ent.op = OP_CKB;
          phase_next  = PH_HUNT1;
        end
        default: begin
          phase_next = (rx_byte == cfg.sync_first) ? PH_HUNT2 : PH_HUNT1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT1;
    end else begin
      phase <= phase_next;
    end
    len_lo    <= len_lo_next;
    cur_len   <= cur_len_next;
    pay_count <= pay_count_next;
  end

endmodule

// File: rtl/ubxfp_fifo.sv
// ----------------------------------------------------------------------------
// ubxfp_fifo
// Short queue of tagged bytes between front and back.
// ----------------------------------------------------------------------------
module ubxfp_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ubxfp_pkg::qent_t  push_ent,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output ubxfp_pkg::qent_t  pop_ent
);
  import ubxfp_pkg::*;

  qent_t            mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QCW-1:0]   count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == QCW'(QDEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_ent   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + QCW'(1);
        2'b01:   count <= count - QCW'(1);
        default: count <= count;
      endcase
    end
    if (do_push) begin
      mem[wr_ptr] <= push_ent;
    end
  end

endmodule

// File: rtl/ubxfp_back.sv
// ----------------------------------------------------------------------------
// ubxfp_back
// Checksum and result stage: runs the Fletcher sums over queued bytes,
// emits payload and frame-end results through an output register.
// ----------------------------------------------------------------------------
module ubxfp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              not_empty,
  input  ubxfp_pkg::qent_t  pop_ent,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output ubxfp_pkg::res_t   out_res
);
  import ubxfp_pkg::*;

  logic [7:0]  cur_class;
  logic [7:0]  cur_id;
  logic [15:0] cur_len;
  logic [15:0] pay_count;
  logic [7:0]  got_ck_a;
  logic [7:0]  sum_a;
  logic [7:0]  sum_b;
  logic [7:0]  sum_a_add;
  logic [7:0]  sum_b_add;
  logic        emit;
  logic        slot_free;
  logic [7:0]  b;

  assign b         = pop_ent.data;
  assign slot_free = !out_valid || out_ready;
  assign pop       = not_empty && slot_free;
  assign sum_a_add = sum_a + b;
  assign sum_b_add = sum_b + sum_a_add;
  assign emit      = pop && (pop_ent.op == OP_PAY || pop_ent.op == OP_CKB);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= emit;
    end

    if (pop) begin
      unique case (pop_ent.op)
        OP_CLASS: begin
          cur_class <= b;
          sum_a     <= b;
          sum_b     <= b;
        end
        OP_ID: begin
          cur_id <= b;
          sum_a  <= sum_a_add;
          sum_b  <= sum_b_add;
        end
        OP_LENLO: begin
          cur_len <= {8'd0, b};
          sum_a   <= sum_a_add;
          sum_b   <= sum_b_add;
        end
        OP_LENHI: begin
          cur_len[15:8] <= b;
          pay_count     <= '0;
          sum_a         <= sum_a_add;
          sum_b         <= sum_b_add;
        end
        OP_PAY: begin
          sum_a              <= sum_a_add;
          sum_b              <= sum_b_add;
          pay_count          <= pay_count + 16'd1;
          out_res.kind       <= KIND_PAYLOAD;
          out_res.data_byte  <= b;
          out_res.byte_index <= pay_count;
          out_res.msg_class  <= cur_class;
          out_res.msg_id     <= cur_id;
          out_res.frame_len  <= cur_len;
        end
        OP_CKA: begin
          got_ck_a <= b;
        end
        OP_CKB: begin
          out_res.kind       <= (got_ck_a == sum_a && b == sum_b) ? KIND_GOOD : KIND_BAD;
          out_res.data_byte  <= '0;
          out_res.byte_index <= '0;
          out_res.msg_class  <= cur_class;
          out_res.msg_id     <= cur_id;
          out_res.frame_len  <= cur_len;
        end
        default: begin
          got_ck_a <= got_ck_a;
        end
      endcase
    end
  end

endmodule

// File: rtl/ubx_frame_parser.sv
// ----------------------------------------------------------------------------
// ubx_frame_parser
// UBX-style frame parser with 8-bit Fletcher checksum, streaming payload out.
// ----------------------------------------------------------------------------
//
//  Channel   | Dir | Signals                         | Contents
//  ----------+-----+---------------------------------+---------------------------
//  byte in   | in  | s_tvalid s_tready s_tdata[7:0]  | rx_byte
//  result    | out | m_tvalid m_tready m_tdata m_tuser| payload byte or frame end
//  config    | in  | psel penable pwrite paddr pwdata| sync bytes, max length
//
//  One received byte is taken per cycle while the queue has room; each
//  transfer flows front -> queue -> back and, if it yields a result, reaches
//  m_tdata from the back stage's output register once its queue entry is popped.
//  Sustained rate is one byte per cycle while m_tready holds, set by the back stage.
//  rst is synchronous: framing returns to sync hunt, queue and output empty.
//  A stalled output holds the back stage; the front keeps taking bytes until
//  the 4-entry queue fills, then deasserts s_tready.
//
module ubx_frame_parser (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [7:0] data_byte, [23:8] byte_index,
                                 // [31:24] msg_class, [39:32] msg_id,
                                 // [55:40] frame_len
  output logic [1:0]  m_tuser,   // [1:0] kind
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ubxfp_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ubxfp_pkg::*;

  cfg_t       cfg;
  logic       cfg_wr;
  logic [1:0] reg_idx;

  logic       accept;
  logic       push;
  qent_t      push_ent;
  logic       q_full;
  logic       pop;
  logic       q_not_empty;
  qent_t      pop_ent;
  res_t       res;

  // Register file: decode by word index, writes complete in the access phase
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first  <= SYNC_FIRST_RST;
      cfg.sync_second <= SYNC_SECOND_RST;
      cfg.max_len     <= MAX_LEN_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SYNC_FIRST:  cfg.sync_first  <= pwdata[7:0];
        REG_SYNC_SECOND: cfg.sync_second <= pwdata[7:0];
        REG_MAX_LEN:     cfg.max_len     <= pwdata[15:0];
        default:         cfg.max_len     <= cfg.max_len;  // unmapped, ignored
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SYNC_FIRST:  prdata = {24'd0, cfg.sync_first};
      REG_SYNC_SECOND: prdata = {24'd0, cfg.sync_second};
      REG_MAX_LEN:     prdata = {16'd0, cfg.max_len};
      default:         prdata = '0;
    endcase
  end

  // Input side: front accepts whenever the queue has room
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  ubxfp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .accept   (accept),
    .rx_byte  (s_tdata),
    .push     (push),
    .push_ent (push_ent)
  );

  ubxfp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_ent  (push_ent),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_ent   (pop_ent)
  );

  ubxfp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (q_not_empty),
    .pop_ent   (pop_ent),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  // Output packing
  assign m_tuser = res.kind;
  assign m_tdata = {res.frame_len, res.msg_id, res.msg_class, res.byte_index, res.data_byte};

endmodule

// File: dv/ubxfp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ubxfp_checker
// Watches the byte, result and register channels of the frame parser, keeps
// its own copy of the framing state and checksum, and compares every result
// transfer with the oldest predicted one.
// ----------------------------------------------------------------------------
module ubxfp_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [55:0]                   m_tdata,   // [7:0] data_byte, [23:8] byte_index,
                                                   // [31:24] msg_class, [39:32] msg_id,
                                                   // [55:40] frame_len
  input  logic [1:0]                    m_tuser,   // [1:0] kind
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [ubxfp_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output int unsigned                   fail_count,
  output int unsigned                   pending
);
  import ubxfp_pkg::*;

  typedef enum logic [3:0] {
    HUNT_SYNC1,
    HUNT_SYNC2,
    TAKE_CLASS,
    TAKE_ID,
    TAKE_LEN_LO,
    TAKE_LEN_HI,
    TAKE_PAYLOAD,
    TAKE_CK_A,
    TAKE_CK_B
  } parse_phase_t;

  cfg_t         cfg;
  parse_phase_t phase;
  logic [7:0]   cls, id, rx_ck_a, ck_a, ck_b;
  logic [15:0]  len, pay_cnt;
  res_t         frame_q[$];
  res_t         exp_r, got_r;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic expect_result(input logic [1:0] kind, input logic [7:0] data,
                               input logic [15:0] idx);
    res_t r;
    r.kind       = kind;
    r.data_byte  = data;
    r.byte_index = idx;
    r.msg_class  = cls;
    r.msg_id     = id;
    r.frame_len  = len;
    frame_q.push_back(r);
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg.sync_first  = SYNC_FIRST_RST;
      cfg.sync_second = SYNC_SECOND_RST;
      cfg.max_len     = MAX_LEN_RST;
      phase   = HUNT_SYNC1;
      cls     = '0;
      id      = '0;
      len     = '0;
      pay_cnt = '0;
      rx_ck_a = '0;
      ck_a    = '0;
      ck_b    = '0;
      frame_q.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        // Fletcher sums cover class, id, length and payload
        if (phase == TAKE_CLASS) begin
          ck_a = s_tdata;
          ck_b = s_tdata;
        end else if (phase >= TAKE_ID && phase <= TAKE_PAYLOAD) begin
          ck_a = ck_a + s_tdata;
          ck_b = ck_b + ck_a;
        end
        case (phase)
          HUNT_SYNC2:  phase = (s_tdata == cfg.sync_second) ? TAKE_CLASS : HUNT_SYNC1;
          TAKE_CLASS: begin
            cls   = s_tdata;
            phase = TAKE_ID;
          end
          TAKE_ID: begin
            id    = s_tdata;
            phase = TAKE_LEN_LO;
          end
          TAKE_LEN_LO: begin
            len   = {8'h00, s_tdata};
            phase = TAKE_LEN_HI;
          end
          TAKE_LEN_HI: begin
            len[15:8] = s_tdata;
            pay_cnt   = '0;
            // zero or oversize length: drop silently
            phase = (len != 0 && len <= cfg.max_len) ? TAKE_PAYLOAD : HUNT_SYNC1;
          end
          TAKE_PAYLOAD: begin
            expect_result(KIND_PAYLOAD, s_tdata, pay_cnt);
            pay_cnt = pay_cnt + 1'b1;
            if (pay_cnt >= len) phase = TAKE_CK_A;
          end
          TAKE_CK_A: begin
            rx_ck_a = s_tdata;
            phase   = TAKE_CK_B;
          end
          TAKE_CK_B: begin
            expect_result((rx_ck_a == ck_a && s_tdata == ck_b) ? KIND_GOOD : KIND_BAD,
                          8'h00, 16'h0000);
            phase = HUNT_SYNC1;
          end
          default: phase = (s_tdata == cfg.sync_first) ? HUNT_SYNC2 : HUNT_SYNC1;
        endcase
      end

      // register writes take effect after this edge's byte; unknown indexes
      // fall through
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_SYNC_FIRST:  cfg.sync_first  = pwdata[7:0];
          REG_SYNC_SECOND: cfg.sync_second = pwdata[7:0];
          REG_MAX_LEN:     cfg.max_len     = pwdata[15:0];
          default: ;
        endcase
      end

      if (m_tvalid && m_tready) begin
        got_r.kind       = m_tuser;
        got_r.data_byte  = m_tdata[7:0];
        got_r.byte_index = m_tdata[23:8];
        got_r.msg_class  = m_tdata[31:24];
        got_r.msg_id     = m_tdata[39:32];
        got_r.frame_len  = m_tdata[55:40];
        if (frame_q.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, actual tuser %0h tdata %h",
                   $time, m_tuser, m_tdata);
          fail_count++;
        end else begin
          exp_r = frame_q.pop_front();
          check_field("kind",       exp_r.kind,       got_r.kind);
          check_field("data_byte",  exp_r.data_byte,  got_r.data_byte);
          check_field("byte_index", exp_r.byte_index, got_r.byte_index);
          check_field("msg_class",  exp_r.msg_class,  got_r.msg_class);
          check_field("msg_id",     exp_r.msg_id,     got_r.msg_id);
          check_field("frame_len",  exp_r.frame_len,  got_r.frame_len);
        end
      end
    end
    pending = frame_q.size();
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Frame parser bench: feeds byte streams of well-formed, corrupted and broken
// frames under several register settings, with random gaps on both streams,
// and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
  import ubxfp_pkg::*;

  // index past the register list, writes to it must be ignored
  localparam logic [1:0] REG_UNUSED = 2'd3;
  // receiver hold-off used to fill the parser queue and back up the input
  localparam int unsigned LONG_HOLD = 300;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [7:0]           s_tdata;    // [7:0] rx_byte
  logic                 m_tvalid;
  logic                 m_tready;
  logic [55:0]          m_tdata;    // [7:0] data_byte, [23:8] byte_index,
                                    // [31:24] msg_class, [39:32] msg_id,
                                    // [55:40] frame_len
  logic [1:0]           m_tuser;    // [1:0] kind
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  int unsigned          fail_count;
  int unsigned          pending;

  // stimulus-side copy of the registers, used to build frames that fit
  logic [7:0]           sync1_cfg   = SYNC_FIRST_RST;
  logic [7:0]           sync2_cfg   = SYNC_SECOND_RST;
  logic [15:0]          max_len_cfg = MAX_LEN_RST;

  int unsigned          n_sent      = 0;
  int unsigned          tx_gap_max  = 12;
  int unsigned          rx_gap_max  = 12;
  bit                   tx_burst    = 1'b0;  // sender: no gaps at all
  bit                   hold_req    = 1'b0;  // receiver: one long hold-off

  ubx_frame_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  ubxfp_checker chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  // One byte transfer. A random gap drops tvalid first; with no gap tvalid
  // simply stays up for the next byte.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, tx_gap_max);
    if (gap != 0) begin
      @(negedge clk) s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    n_sent++;
  endtask

  // Sync, header, payload and checksum. A frame the parser will drop stops
  // after the length; cut < len truncates the payload and leaves out the
  // checksum; flip_a/flip_b corrupt the checksum bytes.
  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len, input int unsigned cut,
                            input logic [7:0] flip_a, input logic [7:0] flip_b);
    logic [7:0] body[$];
    logic [7:0] sum_a, sum_b;
    bit         taken;
    taken = (len != 0 && len <= max_len_cfg);
    body  = '{cls, id, len[7:0], len[15:8]};
    if (taken)
      for (int unsigned i = 0; i < len && i < cut; i++)
        body.push_back(8'($urandom_range(0, 255)));
    sum_a = '0;
    sum_b = '0;
    send_byte(sync1_cfg);
    send_byte(sync2_cfg);
    foreach (body[i]) begin
      sum_a = sum_a + body[i];
      sum_b = sum_b + sum_a;
      send_byte(body[i]);
    end
    if (taken && cut >= len) begin
      send_byte(sum_a ^ flip_a);
      send_byte(sum_b ^ flip_b);
    end
  endtask

  // Mostly good frames with random content; the rest are line noise, bad
  // second sync, zero/oversize lengths, truncated payloads and bad checksums.
  task automatic send_random_frame();
    int unsigned pick, len, top_len, cut;
    logic [7:0]  flip_a, flip_b;
    tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
    if (pick < 5) begin
      send_byte(sync1_cfg);
      send_byte(sync2_cfg ^ 8'($urandom_range(1, 255)));
      return;
    end
    top_len = (max_len_cfg < 12) ? max_len_cfg : 12;
    if (pick < 10)
      len = 0;
    else if (pick < 15) begin
      if (max_len_cfg == 16'hFFFF) len = 0;
      else len = max_len_cfg + 1 + $urandom_range(0, 3);
      if (len > 16'hFFFF) len = 16'hFFFF;
    end else if (pick < 20 && max_len_cfg <= 40)
      len = max_len_cfg;
    else
      len = $urandom_range(1, top_len);
    cut    = (len > 0 && $urandom_range(0, 24) == 0) ? $urandom_range(0, len - 1) : len;
    flip_a = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
    flip_b = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
    send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'(len), cut,
               flip_a, flip_b);
  endtask

  // APB write: setup cycle, then access cycle; pready is waited on.
  task automatic cfg_write(input logic [1:0] reg_sel, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= val;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (reg_sel)
      REG_SYNC_FIRST:  sync1_cfg   = val[7:0];
      REG_SYNC_SECOND: sync2_cfg   = val[7:0];
      REG_MAX_LEN:     max_len_cfg = val[15:0];
      default: ;
    endcase
  endtask

  // Drain: all predicted results out, then a wait that lets bytes which make
  // no result pass through the queue as well.
  task automatic settle();
    @(negedge clk) s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Result receiver: random stalls per transfer, quiet stretches now and
  // then, and one long hold-off on request.
  initial begin
    int unsigned stall;
    m_tready = 1'b0;
    forever begin
      if (hold_req) begin
        @(negedge clk) m_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 39) == 0) rx_gap_max = (rx_gap_max == 0) ? 12 : 0;
      stall = $urandom_range(0, rx_gap_max);
      if (stall != 0) begin
        @(negedge clk) m_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Stimulus and verdict
  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // directed, reset register values
    tx_gap_max = 0;
    send_frame(8'hFF, 8'h00, 16'd1, 1, 8'h00, 8'h00);   // good, byte extremes
    send_frame(8'h00, 8'hFF, 16'd1, 1, 8'h01, 8'h00);   // checksum A wrong
    send_byte(SYNC_FIRST_RST);                           // second sync mismatch;
    send_byte(SYNC_FIRST_RST);                           // the failed byte is not
    send_byte(SYNC_SECOND_RST);                          // taken as a first sync
    send_frame(8'h05, 8'h01, 16'd0, 0, 8'h00, 8'h00);   // zero length, dropped
    send_frame(8'h05, 8'h02, 16'd256, 256, 8'h00, 8'h00); // one over the limit

    while (n_sent < 130) send_random_frame();
    settle();

    // low extremes: sync 00/FF, only single-byte payloads
    cfg_write(REG_SYNC_FIRST, 32'h0000_0000);
    cfg_write(REG_SYNC_SECOND, 32'h0000_00FF);
    cfg_write(REG_MAX_LEN, 32'h0000_0001);
    while (n_sent < 230) send_random_frame();
    settle();

    // high extremes: sync FF/00, full 16-bit length limit
    cfg_write(REG_SYNC_FIRST, 32'h0000_00FF);
    cfg_write(REG_SYNC_SECOND, 32'h0000_0000);
    cfg_write(REG_MAX_LEN, 32'h0000_FFFF);
    while (n_sent < 300) send_random_frame();
    // long frame sent back to back while the receiver holds off,
    // so the queue fills and s_tready drops
    tx_burst = 1'b1;
    hold_req = 1'b1;
    send_frame(8'h5A, 8'hA5, 16'd260, 260, 8'h00, 8'h00);
    tx_burst = 1'b0;
    while (n_sent < 480) send_random_frame();
    settle();

    // random sync pair (sometimes equal), short random limit
    cfg_write(REG_SYNC_FIRST, $urandom);
    cfg_write(REG_SYNC_SECOND,
              ($urandom_range(0, 3) == 0) ? {24'h0, sync1_cfg} : $urandom);
    cfg_write(REG_MAX_LEN, {16'($urandom_range(0, 65535)), 16'($urandom_range(2, 40))});
    while (n_sent < 580) send_random_frame();
    settle();

    // back to standard values with junk in the upper data bits,
    // plus a write past the register list
    cfg_write(REG_UNUSED, $urandom);
    cfg_write(REG_SYNC_FIRST, {24'($urandom), SYNC_FIRST_RST});
    cfg_write(REG_SYNC_SECOND, {24'($urandom), SYNC_SECOND_RST});
    cfg_write(REG_MAX_LEN, {16'($urandom), MAX_LEN_RST});
    while (n_sent < 660) send_random_frame();
    settle();

    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
